// ----- sv/wsdf_pkg.sv -----
// shared types, constants and helper functions of the websocket frame deframer
`timescale 1ns / 1ps

package wsdf_pkg;

    // width of the payload length counter
    localparam int LEN_BITS = 64;
    // compare width for the length limit check
    localparam int CMP_BITS = (LEN_BITS > 32) ? LEN_BITS : 32;
    // transfer queue depth between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // limit reset value
    localparam logic [31:0] MAX_LEN_RESET = 32'(1 * 1024 * 1024);

    // 7-bit length codes that select an extended length
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    // extension byte counts minus one
    localparam logic [2:0] EXT16_CNT = 3'd1;
    localparam logic [2:0] EXT64_CNT = 3'd7;
    localparam logic [2:0] KEY_CNT   = 3'd3;

    // opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // frame end status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CLOSED  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_TOO_BIG = 2'd3;

    // parser phases, one-hot
    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_HALT    = 6'b100000
    } t_phase;

    // one command from the parser to the output stage
    typedef struct packed {
        logic       has_payload;
        logic [7:0] raw_byte;
        logic [7:0] key_byte;
        logic [3:0] opcode;
        logic       fin;
        logic       frame_end;
        logic [1:0] status;
    } t_cmd;

    // queue handshake toward the output stage
    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_stat;

    // status reported when a frame closes
    function automatic logic [1:0] f_close_status(input logic [3:0] op);
        logic [1:0] st;
        if (op == OP_TEXT || op == OP_BINARY || op == OP_PING || op == OP_PONG) begin
            st = ST_OK;
        end else if (op == OP_CLOSE) begin
            st = ST_CLOSED;
        end else begin
            st = ST_UNKNOWN;
        end
        return st;
    endfunction

endpackage

// ----- sv/wsdf_front.sv -----
// header parser: accepts frame bytes and turns them into output commands
`timescale 1ns / 1ps

module wsdf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    output logic                o_push,
    output wsdf_pkg::t_cmd      o_cmd
);

    wsdf_pkg::t_phase                  r_phase, n_phase;
    logic [7:0]                        r_hdr, n_hdr;
    logic [wsdf_pkg::LEN_BITS-1:0]     r_rem, n_rem;
    logic [2:0]                        r_cnt, n_cnt;
    logic [31:0]                       r_key, n_key;
    logic [1:0]                        r_pos, n_pos;
    logic                              r_masked, n_masked;
    logic [31:0]                       r_max_len;

    logic [wsdf_pkg::LEN_BITS-1:0]     w_len_ext;
    logic [wsdf_pkg::LEN_BITS-1:0]     w_len_cand;
    logic                              w_masked_now;
    logic                              w_too_big;
    logic                              w_len_zero;
    logic [7:0]                        w_key_byte;
    logic [1:0]                        w_close_st;
    logic                              w_len_done;
    logic [6:0]                        w_len7;

    // length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= wsdf_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    // extended length shift with saturation
    always_comb begin
        if (r_rem[wsdf_pkg::LEN_BITS-1 -: 8] != 8'd0) begin
            w_len_ext = '1;
        end else begin
            w_len_ext = {r_rem[wsdf_pkg::LEN_BITS-9:0], i_rx_byte};
        end
    end

    // candidate length and checks once the length is known
    assign w_len7       = i_rx_byte[6:0];
    assign w_len_cand   = (r_phase == wsdf_pkg::PH_HDR1) ?
                          wsdf_pkg::LEN_BITS'(w_len7) : w_len_ext;
    assign w_masked_now = (r_phase == wsdf_pkg::PH_HDR1) ? i_rx_byte[7] : r_masked;
    assign w_too_big    = wsdf_pkg::CMP_BITS'(w_len_cand) > wsdf_pkg::CMP_BITS'(r_max_len);
    assign w_len_zero   = (w_len_cand == '0);
    assign w_close_st   = wsdf_pkg::f_close_status(r_hdr[3:0]);

    // key byte for the current payload position, first key byte in the top
    always_comb begin
        case (r_pos)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            2'd3:    w_key_byte = r_key[7:0];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    // phase sequencing
    always_comb begin
        n_phase    = r_phase;
        n_hdr      = r_hdr;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_key      = r_key;
        n_pos      = r_pos;
        n_masked   = r_masked;
        w_len_done = 1'b0;
        o_push     = 1'b0;
        o_cmd             = '0;
        o_cmd.opcode      = r_hdr[3:0];
        o_cmd.fin         = r_hdr[7];

        if (i_accept) begin
            case (r_phase)
                wsdf_pkg::PH_HDR0: begin
                    n_hdr   = i_rx_byte;
                    n_phase = wsdf_pkg::PH_HDR1;
                end
                wsdf_pkg::PH_HDR1: begin
                    n_masked = i_rx_byte[7];
                    if (w_len7 == wsdf_pkg::LEN7_EXT16 || w_len7 == wsdf_pkg::LEN7_EXT64) begin
                        n_rem   = '0;
                        n_cnt   = (w_len7 == wsdf_pkg::LEN7_EXT16) ?
                                  wsdf_pkg::EXT16_CNT : wsdf_pkg::EXT64_CNT;
                        n_phase = wsdf_pkg::PH_EXTLEN;
                    end else begin
                        n_rem      = w_len_cand;
                        w_len_done = 1'b1;
                    end
                end
                wsdf_pkg::PH_EXTLEN: begin
                    n_rem = w_len_cand;
                    if (r_cnt == 3'd0) begin
                        w_len_done = 1'b1;
                    end else begin
                        n_cnt = r_cnt - 3'd1;
                    end
                end
                wsdf_pkg::PH_MASK: begin
                    n_key = {r_key[23:0], i_rx_byte};
                    if (r_cnt != 3'd0) begin
                        n_cnt = r_cnt - 3'd1;
                    end else begin
                        n_pos = 2'd0;
                        if (r_rem == '0) begin
                            o_push          = 1'b1;
                            o_cmd.frame_end = 1'b1;
                            o_cmd.status    = w_close_st;
                            n_phase = (w_close_st == wsdf_pkg::ST_OK) ?
                                      wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_HALT;
                        end else begin
                            n_phase = wsdf_pkg::PH_PAYLOAD;
                        end
                    end
                end
                wsdf_pkg::PH_PAYLOAD: begin
                    o_push            = 1'b1;
                    o_cmd.has_payload = 1'b1;
                    o_cmd.raw_byte    = i_rx_byte;
                    o_cmd.key_byte    = r_masked ? w_key_byte : 8'd0;
                    n_pos = r_pos + 2'd1;
                    n_rem = r_rem - wsdf_pkg::LEN_BITS'(1);
                    if (r_rem == wsdf_pkg::LEN_BITS'(1)) begin
                        o_cmd.frame_end = 1'b1;
                        o_cmd.status    = w_close_st;
                        n_phase = (w_close_st == wsdf_pkg::ST_OK) ?
                                  wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_HALT;
                    end
                end
                wsdf_pkg::PH_HALT: begin
                    n_phase = wsdf_pkg::PH_HALT;
                end
                default: begin
                    n_phase = wsdf_pkg::PH_HALT;
                end
            endcase

            // length complete: limit check and key phase for masked frames, else payload or frame end
            if (w_len_done) begin
                if (w_masked_now) begin
                    if (w_too_big) begin
                        o_push          = 1'b1;
                        o_cmd.frame_end = 1'b1;
                        o_cmd.status    = wsdf_pkg::ST_TOO_BIG;
                        n_phase         = wsdf_pkg::PH_HALT;
                    end else begin
                        n_phase = wsdf_pkg::PH_MASK;
                        n_cnt   = wsdf_pkg::KEY_CNT;
                        n_key   = '0;
                    end
                end else begin
                    n_key = '0;
                    n_pos = 2'd0;
                    if (w_len_zero) begin
                        o_push          = 1'b1;
                        o_cmd.frame_end = 1'b1;
                        o_cmd.status    = w_close_st;
                        n_phase = (w_close_st == wsdf_pkg::ST_OK) ?
                                  wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_HALT;
                    end else begin
                        n_phase = wsdf_pkg::PH_PAYLOAD;
                    end
                end
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsdf_pkg::PH_HDR0;
            r_hdr    <= '0;
            r_rem    <= '0;
            r_cnt    <= '0;
            r_key    <= '0;
            r_pos    <= '0;
            r_masked <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_hdr    <= n_hdr;
            r_rem    <= n_rem;
            r_cnt    <= n_cnt;
            r_key    <= n_key;
            r_pos    <= n_pos;
            r_masked <= n_masked;
        end
    end

endmodule

// ----- sv/wsdf_queue.sv -----
// short command queue between the parser and the output stage
`timescale 1ns / 1ps

module wsdf_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  wsdf_pkg::t_cmd        i_cmd,
    input  logic                  i_pop,
    output wsdf_pkg::t_queue_stat o_stat,
    output wsdf_pkg::t_cmd        o_cmd
);

    wsdf_pkg::t_cmd                        r_mem [wsdf_pkg::QUEUE_DEPTH];
    logic [wsdf_pkg::QUEUE_PTR_BITS-1:0]   r_wr_ptr;
    logic [wsdf_pkg::QUEUE_PTR_BITS-1:0]   r_rd_ptr;
    logic [wsdf_pkg::QUEUE_CNT_BITS-1:0]   r_count;
    logic                                  w_do_push;
    logic                                  w_do_pop;

    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == wsdf_pkg::QUEUE_CNT_BITS'(wsdf_pkg::QUEUE_DEPTH));
    assign o_cmd        = r_mem[r_rd_ptr];
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && o_stat.valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + wsdf_pkg::QUEUE_PTR_BITS'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + wsdf_pkg::QUEUE_PTR_BITS'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + wsdf_pkg::QUEUE_CNT_BITS'(1);
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - wsdf_pkg::QUEUE_CNT_BITS'(1);
            end
        end
    end

endmodule

// ----- sv/wsdf_back.sv -----
// output stage: unmasks payload bytes and holds the result register
`timescale 1ns / 1ps

module wsdf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  wsdf_pkg::t_cmd        i_cmd,
    output logic                  o_pop,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic                  o_has_payload,
    output logic [7:0]            o_payload_byte,
    output logic [3:0]            o_frame_opcode,
    output logic                  o_fin_flag,
    output logic                  o_frame_end,
    output logic [1:0]            o_frame_status
);

    logic       r_valid;
    logic       r_has_payload;
    logic [7:0] r_payload_byte;
    logic [3:0] r_frame_opcode;
    logic       r_fin_flag;
    logic       r_frame_end;
    logic [1:0] r_frame_status;

    // take the next command when the register is empty or being drained
    assign o_pop = i_q_valid && (!r_valid || !i_stall);

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // result payload with unmasking
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_has_payload  <= i_cmd.has_payload;
            r_payload_byte <= i_cmd.raw_byte ^ i_cmd.key_byte;
            r_frame_opcode <= i_cmd.opcode;
            r_fin_flag     <= i_cmd.fin;
            r_frame_end    <= i_cmd.frame_end;
            r_frame_status <= i_cmd.status;
        end
    end

    assign o_valid        = r_valid;
    assign o_has_payload  = r_has_payload;
    assign o_payload_byte = r_payload_byte;
    assign o_frame_opcode = r_frame_opcode;
    assign o_fin_flag     = r_fin_flag;
    assign o_frame_end    = r_frame_end;
    assign o_frame_status = r_frame_status;

endmodule

// ----- sv/websocket_frame_deframer_top.sv -----
// top level of the websocket frame deframer
`timescale 1ns / 1ps

// Receive-side WebSocket frame deframer. One frame-stream byte is taken per
// cycle whenever the four-entry command queue has room; the header parser
// handles every byte (header, extended length, masking key, payload) with no
// stall of its own, so the sustained rate is one byte per clock. Results pass
// the queue, which absorbs up to four while the output side stalls, then the
// output register. Header bytes give no result, except the one that completes
// an empty frame or finds a masked frame too big. After any status other than
// ok (peer closed, unknown opcode, too big) all further bytes are taken and
// dropped until reset. The user must write the masked-frame length limit through
// i_cfg_we / i_cfg_data while the block is idle, which it does not enforce.

module websocket_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_has_payload,
    output logic [7:0]  o_payload_byte,
    output logic [3:0]  o_frame_opcode,
    output logic        o_fin_flag,
    output logic        o_frame_end,
    output logic [1:0]  o_frame_status
);

    logic                  w_accept;
    logic                  w_push;
    logic                  w_pop;
    wsdf_pkg::t_cmd        w_push_cmd;
    wsdf_pkg::t_cmd        w_head_cmd;
    wsdf_pkg::t_queue_stat w_q_stat;

    // input transfer when the queue has room
    assign o_stall  = w_q_stat.full;
    assign w_accept = i_valid && !w_q_stat.full;

    wsdf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_rx_byte  (i_rx_byte),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    wsdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_cmd   (w_head_cmd)
    );

    wsdf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_stat.valid),
        .i_cmd          (w_head_cmd),
        .o_pop          (w_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_has_payload  (o_has_payload),
        .o_payload_byte (o_payload_byte),
        .o_frame_opcode (o_frame_opcode),
        .o_fin_flag     (o_fin_flag),
        .o_frame_end    (o_frame_end),
        .o_frame_status (o_frame_status)
    );

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the websocket frame deframer
`timescale 1ns / 1ps

module testbench;

    // run limits
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 250;

    // how a frame encodes its payload length
    typedef enum int {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } t_len_form;

    // one result transfer, packed in port order
    typedef struct packed {
        logic       has_payload;
        logic [7:0] payload;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
        logic [1:0] status;
    } t_deframe_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid    = 1'b0;
    logic [7:0]  i_rx_byte  = '0;
    logic        i_stall    = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_has_payload;
    logic [7:0]  o_payload_byte;
    logic [3:0]  o_frame_opcode;
    logic        o_fin_flag;
    logic        o_frame_end;
    logic [1:0]  o_frame_status;

    websocket_frame_deframer_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_has_payload  (o_has_payload),
        .o_payload_byte (o_payload_byte),
        .o_frame_opcode (o_frame_opcode),
        .o_fin_flag     (o_fin_flag),
        .o_frame_end    (o_frame_end),
        .o_frame_status (o_frame_status)
    );

    // stream bytes not yet offered, and results still owed by the block
    logic [7:0]      pending_bytes[$];
    t_deframe_result expected_results[$];

    int  bytes_queued   = 0;
    int  accepted_bytes = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  rx_taken       = 1'b0;

    // predicted parser state
    wsdf_pkg::t_phase                deframe_phase = wsdf_pkg::PH_HDR0;
    logic [7:0]                      frame_head    = '0;
    logic [wsdf_pkg::LEN_BITS-1:0]   bytes_left    = '0;
    logic [2:0]                      count_left    = '0;
    logic [31:0]                     key_word      = '0;
    logic [1:0]                      key_pos       = '0;
    logic                            frame_masked  = 1'b0;
    logic [31:0]                     byte_limit    = wsdf_pkg::MAX_LEN_RESET;

    // sender and receiver pacing
    int burst_left   = 8;
    int gap_left     = 0;
    int hold_left    = 0;
    int next_hold_at = 200;
    int stall_mode   = 0;
    int mode_left    = 0;

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result carrying the current frame's opcode and fin bit
    function automatic t_deframe_result make_result(input logic has, input logic [7:0] data,
                                                    input logic last, input logic [1:0] st);
        t_deframe_result r;
        r.has_payload = has;
        r.payload     = data;
        r.opcode      = frame_head[3:0];
        r.fin         = frame_head[7];
        r.last        = last;
        r.status      = st;
        return r;
    endfunction

    // close the frame: status from the opcode, halt on anything but ok
    task automatic finish_frame(input logic has, input logic [7:0] data);
        logic [3:0] op;
        logic [1:0] st;
        op = frame_head[3:0];
        if (op == wsdf_pkg::OP_TEXT || op == wsdf_pkg::OP_BINARY ||
            op == wsdf_pkg::OP_PING || op == wsdf_pkg::OP_PONG) begin
            st = wsdf_pkg::ST_OK;
            deframe_phase = wsdf_pkg::PH_HDR0;
        end else begin
            st = (op == wsdf_pkg::OP_CLOSE) ? wsdf_pkg::ST_CLOSED : wsdf_pkg::ST_UNKNOWN;
            deframe_phase = wsdf_pkg::PH_HALT;
        end
        expected_results.push_back(make_result(has, data, 1'b1, st));
    endtask

    // payload length is complete: limit check and key for masked frames, else payload or frame end
    task automatic length_known();
        if (frame_masked) begin
            if (wsdf_pkg::CMP_BITS'(bytes_left) > wsdf_pkg::CMP_BITS'(byte_limit)) begin
                deframe_phase = wsdf_pkg::PH_HALT;
                expected_results.push_back(make_result(1'b0, 8'h00, 1'b1,
                                                       wsdf_pkg::ST_TOO_BIG));
            end else begin
                deframe_phase = wsdf_pkg::PH_MASK;
                count_left = wsdf_pkg::KEY_CNT;
                key_word = '0;
            end
        end else begin
            key_word = '0;
            key_pos = '0;
            if (bytes_left == '0) begin
                finish_frame(1'b0, 8'h00);
            end else begin
                deframe_phase = wsdf_pkg::PH_PAYLOAD;
            end
        end
    endtask

    // advance the predicted parser by one accepted byte
    task automatic predict_deframe(input logic [7:0] b);
        logic [6:0]  len7;
        logic [31:0] key_sel;
        logic [7:0]  data;
        case (deframe_phase)
            wsdf_pkg::PH_HDR0: begin
                frame_head = b;
                deframe_phase = wsdf_pkg::PH_HDR1;
            end
            wsdf_pkg::PH_HDR1: begin
                len7 = b[6:0];
                frame_masked = b[7];
                bytes_left = wsdf_pkg::LEN_BITS'(len7);
                if (len7 == wsdf_pkg::LEN7_EXT16 || len7 == wsdf_pkg::LEN7_EXT64) begin
                    bytes_left = '0;
                    count_left = (len7 == wsdf_pkg::LEN7_EXT16) ?
                                 wsdf_pkg::EXT16_CNT : wsdf_pkg::EXT64_CNT;
                    deframe_phase = wsdf_pkg::PH_EXTLEN;
                end else begin
                    length_known();
                end
            end
            wsdf_pkg::PH_EXTLEN: begin
                // saturate when the length no longer fits
                if ((bytes_left >> (wsdf_pkg::LEN_BITS - 8)) != '0) begin
                    bytes_left = '1;
                end else begin
                    bytes_left = {bytes_left[wsdf_pkg::LEN_BITS-9:0], b};
                end
                if (count_left == 3'd0) begin
                    length_known();
                end else begin
                    count_left = count_left - 3'd1;
                end
            end
            wsdf_pkg::PH_MASK: begin
                key_word = {key_word[23:0], b};
                if (count_left != 3'd0) begin
                    count_left = count_left - 3'd1;
                end else begin
                    key_pos = '0;
                    if (bytes_left == '0) begin
                        finish_frame(1'b0, 8'h00);
                    end else begin
                        deframe_phase = wsdf_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsdf_pkg::PH_PAYLOAD: begin
                key_sel = key_word >> (8 * (3 - key_pos));
                data = b ^ (frame_masked ? key_sel[7:0] : 8'h00);
                key_pos = key_pos + 2'd1;
                bytes_left = bytes_left - wsdf_pkg::LEN_BITS'(1);
                if (bytes_left == '0) begin
                    finish_frame(1'b1, data);
                end else begin
                    expected_results.push_back(make_result(1'b1, data, 1'b0,
                                                           wsdf_pkg::ST_OK));
                end
            end
            default: begin
                // halted: bytes are dropped
                deframe_phase = wsdf_pkg::PH_HALT;
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what, input t_deframe_result want,
                                 input t_deframe_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch (%s) cycle %0d", what, cycle_count);
            $display("  expected has=%0d byte=%02h op=%0h fin=%0d end=%0d st=%0d",
                     want.has_payload, want.payload, want.opcode, want.fin,
                     want.last, want.status);
            $display("  got      has=%0d byte=%02h op=%0h fin=%0d end=%0d st=%0d",
                     got.has_payload, got.payload, got.opcode, got.fin,
                     got.last, got.status);
        end
    endtask

    // input acceptance feeds the predictor, output transfers are checked
    always @(posedge i_clk) begin : monitor
        t_deframe_result got;
        t_deframe_result want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
        rx_taken = i_rst_n && i_valid && !o_stall;
        if (rx_taken) begin
            accepted_bytes++;
            predict_deframe(i_rx_byte);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_has_payload, o_payload_byte, o_frame_opcode, o_fin_flag,
                   o_frame_end, o_frame_status};
            if (expected_results.size() == 0) begin
                flag_mismatch("unexpected result", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    flag_mismatch("wrong result", want, got);
                end
            end
        end
    end

    // sender: bursts of random length with random gaps
    always @(negedge i_clk) begin : driver
        logic       nv;
        logic [7:0] nb;
        nv = i_valid;
        nb = i_rx_byte;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!i_valid || rx_taken) begin
            nv = 1'b0;
            nb = 8'($urandom);
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_bytes.size() > 0) begin
                nb = pending_bytes.pop_front();
                nv = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_valid <= nv;
        i_rx_byte <= nb;
    end

    // receiver: stall modes of random length, plus long hold-offs
    always @(negedge i_clk) begin : receiver
        logic ns;
        ns = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
            ns = 1'b1;
        end else if (i_rst_n && accepted_bytes >= next_hold_at) begin
            hold_left = HOLD_CYCLES;
            next_hold_at += 700;
            ns = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: ns = 1'b0;
                1: ns = ($urandom_range(0, 3) == 0);
                default: ns = ($urandom_range(0, 3) != 0);
            endcase
        end
        i_stall <= ns;
    end

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // header, optional extended length and key, then the payload if asked
    task automatic push_frame(input logic [7:0] head, input bit masked,
                              input logic [63:0] len, input t_len_form form, input bit body);
        logic [6:0] len7;
        longint     k;
        case (form)
            LEN_EXT16: len7 = wsdf_pkg::LEN7_EXT16;
            LEN_EXT64: len7 = wsdf_pkg::LEN7_EXT64;
            default:   len7 = len[6:0];
        endcase
        push_byte(head);
        push_byte({masked, len7});
        if (form == LEN_EXT16) begin
            push_byte(len[15:8]);
            push_byte(len[7:0]);
        end else if (form == LEN_EXT64) begin
            for (k = 7; k >= 0; k--) begin
                push_byte(len[8*k +: 8]);
            end
        end
        if (masked) begin
            repeat (4) push_byte(8'($urandom));
        end
        if (body) begin
            for (k = 0; k < len; k++) begin
                push_byte(8'($urandom));
            end
        end
    endtask

    // well-formed frame with an ok opcode, length within the current limit when masked
    task automatic push_random_frame();
        logic [3:0]  op;
        bit          masked;
        int unsigned len;
        int          pick;
        t_len_form   form;
        case ($urandom_range(0, 3))
            0: op = wsdf_pkg::OP_TEXT;
            1: op = wsdf_pkg::OP_BINARY;
            2: op = wsdf_pkg::OP_PING;
            default: op = wsdf_pkg::OP_PONG;
        endcase
        masked = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        form = LEN_SHORT;
        if (pick < 55) begin
            len = $urandom_range(0, 10);
        end else if (pick < 80) begin
            len = $urandom_range(11, 125);
        end else if (pick < 95) begin
            form = LEN_EXT16;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
        end else begin
            form = LEN_EXT64;
            len = $urandom_range(0, 40);
        end
        if (masked && len > byte_limit) begin
            len = byte_limit;
        end
        push_frame({1'($urandom), 3'($urandom), op}, masked, 64'(len), form, 1'b1);
    endtask

    task automatic push_random_frames(input int n);
        int target;
        target = bytes_queued + n;
        while (bytes_queued < target) begin
            push_random_frame();
        end
    endtask

    // everything sent, every result back, block settled
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || i_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        byte_limit = value;
    endtask

    // stimulus
    initial begin : stimulus
        logic [3:0]  op;
        int unsigned len;
        int          kind;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each ok opcode, empty frame, both extended length forms
        push_frame({1'b1, 3'b000, wsdf_pkg::OP_TEXT}, 1'b0, 64'd0, LEN_SHORT, 1'b1);
        push_frame({1'b1, 3'b000, wsdf_pkg::OP_PING}, 1'b1, 64'd1, LEN_SHORT, 1'b1);
        push_frame({1'b1, 3'b111, wsdf_pkg::OP_PONG}, 1'b0, 64'd2, LEN_EXT16, 1'b1);
        push_frame({1'b0, 3'b000, wsdf_pkg::OP_BINARY}, 1'b0, 64'd1, LEN_EXT64, 1'b1);
        push_random_frames(420);
        wait_idle();

        // widest limit
        write_limit(32'hFFFF_FFFF);
        push_random_frames(380);
        wait_idle();

        // zero limit: masked frames must be empty
        write_limit(32'h0000_0000);
        push_random_frames(320);
        wait_idle();

        // small limit, one masked frame exactly at it
        write_limit($urandom_range(20, 300));
        push_frame({1'b1, 3'b000, wsdf_pkg::OP_TEXT}, 1'b1, 64'(byte_limit),
                   (byte_limit > 125) ? LEN_EXT16 : LEN_SHORT, 1'b1);
        push_random_frames(400);

        // one halting frame closes the run, then bytes that must be dropped
        kind = $urandom_range(0, 3);
        case (kind)
            0: begin
                push_frame({1'($urandom), 3'($urandom), wsdf_pkg::OP_CLOSE}, 1'($urandom),
                           64'($urandom_range(0, 5)), LEN_SHORT, 1'b1);
            end
            1: begin
                op = wsdf_pkg::OP_TEXT;
                while (op == wsdf_pkg::OP_TEXT || op == wsdf_pkg::OP_BINARY ||
                       op == wsdf_pkg::OP_PING || op == wsdf_pkg::OP_PONG ||
                       op == wsdf_pkg::OP_CLOSE) begin
                    op = 4'($urandom);
                end
                push_frame({1'($urandom), 3'($urandom), op}, 1'($urandom),
                           64'($urandom_range(0, 5)), LEN_SHORT, 1'b1);
            end
            2: begin
                len = byte_limit + 1;
                push_frame({1'b1, 3'b000, wsdf_pkg::OP_BINARY}, 1'b1, 64'(len),
                           (len > 125) ? LEN_EXT16 : LEN_SHORT, 1'b0);
            end
            default: begin
                push_frame({1'b1, 3'b000, wsdf_pkg::OP_TEXT}, 1'b1,
                           {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)},
                           LEN_EXT64, 1'b0);
            end
        endcase
        repeat (16) push_byte(8'($urandom));
        wait_idle();

        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
        end
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
